FILE: rtl/core/pcmmd_pkg.sv
// Package of the PC memory map decoder: sizes, constants, codes and types.
`default_nettype none

package pcmmd_pkg;

   // Store sizes in bytes.
   localparam int unsigned RAM_BYTES   = 1048576;
   localparam int unsigned VRAM_BYTES  = 1048576;
   localparam int unsigned PLANE_BYTES = 65536;
   localparam int unsigned PLANE_COUNT = 4;

   localparam int unsigned RAM_AW   = $clog2(RAM_BYTES);
   localparam int unsigned VRAM_AW  = $clog2(VRAM_BYTES);
   localparam int unsigned PLANE_AW = $clog2(PLANE_BYTES);

   // The clearing pass sweeps the deepest store; the others finish early.
   localparam int unsigned CLEAR_DEPTH =
      (RAM_BYTES >= VRAM_BYTES) ?
         ((RAM_BYTES >= PLANE_BYTES) ? RAM_BYTES : PLANE_BYTES) :
         ((VRAM_BYTES >= PLANE_BYTES) ? VRAM_BYTES : PLANE_BYTES);
   localparam int unsigned CLR_AW = $clog2(CLEAR_DEPTH);

   // Legacy video window, A20 address bit and open bus value.
   localparam logic [31:0] WIN_LO   = 32'h000A_0000;
   localparam logic [31:0] WIN_HI   = 32'h000B_0000;
   localparam logic [31:0] A20_BIT  = 32'h0010_0000;
   localparam logic [7:0]  OPEN_BUS = 8'hFF;

   // Access width codes.
   localparam logic [1:0] WC_BYTE = 2'd0;
   localparam logic [1:0] WC_HALF = 2'd1;

   // Configuration register indexes.
   localparam logic [2:0] CSR_A20_ENABLE         = 3'd0;
   localparam logic [2:0] CSR_LFB_BASE           = 3'd1;
   localparam logic [2:0] CSR_VRAM_BYTES         = 3'd2;
   localparam logic [2:0] CSR_BANK_WINDOW_ENABLE = 3'd3;
   localparam logic [2:0] CSR_WINDOW_OFFSET      = 3'd4;
   localparam logic [2:0] CSR_PLANAR_MODE        = 3'd5;
   localparam logic [2:0] CSR_READ_PLANE         = 3'd6;
   localparam logic [2:0] CSR_WRITE_PLANE_MASK   = 3'd7;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RUN,
      ST_FINISH
   } state_type;

   // Where the byte of a read comes from.
   typedef enum logic [2:0] {
      SRC_NONE,
      SRC_OPEN,
      SRC_MAIN,
      SRC_VIDEO,
      SRC_PLANE
   } src_type;

endpackage

`default_nettype wire

FILE: rtl/core/pc_memory_map_decoder.sv
// Top level of the PC memory map decoder with framebuffer, bank window and VGA planes.
//
//  Channel  Direction  Handshake             Payload
//  req      in         req_valid/req_stall   req_kind, req_width_code, req_address,
//                                            req_write_data
//  rsp      out        rsp_valid/rsp_stall   rsp_read_data
//  csr      in         csr_write_enable      csr_index, csr_write_data
//
// An access of n bytes (n = 1, 2 or 4) issues its bytes in turn, each on the
// single port of the byte-wide memory that byte decodes to, then merges the last read
// byte in the finishing state. The next beat is taken in that finishing state once the
// output register is free, so a new access starts as the last one is merged.
// After reset a clearing pass zeroes main RAM, video RAM and the four plane banks, one
// entry a cycle across CLEAR_DEPTH (1,048,576) entries; no request beat is taken meanwhile,
// while configuration writes are accepted as ever.
// A result beat waits in the output register while rsp_stall is high; the block holds off
// the next request while an access runs and while that register is still full at its end.
`default_nettype none

module pc_memory_map_decoder import pcmmd_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_kind,
   input  wire logic [1:0]  req_width_code,
   input  wire logic [31:0] req_address,
   input  wire logic [31:0] req_write_data,

   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [31:0]      rsp_read_data,

   input  wire logic        csr_write_enable,
   input  wire logic [2:0]  csr_index,
   input  wire logic [31:0] csr_write_data
);

   // ------------------------------------------------------------------
   // Configuration registers.
   // ------------------------------------------------------------------
   logic        a20_enable_ff;
   logic [31:0] lfb_base_ff;
   logic [20:0] vram_bytes_ff;
   logic        bank_window_enable_ff;
   logic [19:0] window_offset_ff;
   logic        planar_mode_ff;
   logic [1:0]  read_plane_ff;
   logic [3:0]  write_plane_mask_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a20_enable_ff         <= 1'b0;
         lfb_base_ff           <= '0;
         vram_bytes_ff         <= '0;
         bank_window_enable_ff <= 1'b0;
         window_offset_ff      <= '0;
         planar_mode_ff        <= 1'b0;
         read_plane_ff         <= '0;
         write_plane_mask_ff   <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_A20_ENABLE:         a20_enable_ff         <= csr_write_data[0];
            CSR_LFB_BASE:           lfb_base_ff           <= csr_write_data;
            CSR_VRAM_BYTES:         vram_bytes_ff         <= csr_write_data[20:0];
            CSR_BANK_WINDOW_ENABLE: bank_window_enable_ff <= csr_write_data[0];
            CSR_WINDOW_OFFSET:      window_offset_ff      <= csr_write_data[19:0];
            CSR_PLANAR_MODE:        planar_mode_ff        <= csr_write_data[0];
            CSR_READ_PLANE:         read_plane_ff         <= csr_write_data[1:0];
            CSR_WRITE_PLANE_MASK:   write_plane_mask_ff   <= csr_write_data[3:0];
            default: ;
         endcase
      end
   end

   // Video memory in use is capped at the size actually built.
   logic [31:0] vram_req;
   logic [31:0] vsize;
   assign vram_req = {11'd0, vram_bytes_ff};
   assign vsize    = (vram_req < VRAM_BYTES) ? vram_req : VRAM_BYTES;

   // ------------------------------------------------------------------
   // Sequencer and access registers.
   // ------------------------------------------------------------------
   state_type         state_ff, state_in;
   logic [CLR_AW-1:0] clr_cnt_ff, clr_cnt_in;
   logic [1:0]        idx_ff, idx_in;
   logic [1:0]        last_idx_ff;
   logic              kind_ff;
   logic [31:0]       addr_ff;
   logic [31:0]       wdata_ff;
   logic [31:0]       result_ff;

   // The byte issued in the previous cycle, merged into the result in this one.
   logic              pend_valid_ff;
   src_type           pend_src_ff;
   logic [1:0]        pend_lane_ff;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [31:0]       rsp_data_ff;

   logic              req_accept;
   logic              out_free;
   logic              issue;
   logic              load_out;
   logic              clearing;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      state_in     = state_ff;
      clr_cnt_in   = clr_cnt_ff;
      idx_in       = idx_ff;
      req_stall    = 1'b1;
      issue        = 1'b0;
      load_out     = 1'b0;
      clearing     = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_CLEAR: begin
            clearing   = 1'b1;
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (32'(clr_cnt_ff) == CLEAR_DEPTH - 1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               state_in = ST_RUN;
               idx_in   = '0;
            end
         end
         ST_RUN: begin
            issue = 1'b1;
            if (idx_ff == last_idx_ff) begin
               state_in = ST_FINISH;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               load_out     = 1'b1;
               rsp_valid_in = 1'b1;
               req_stall    = 1'b0;
               if (req_valid) begin
                  state_in = ST_RUN;
                  idx_in   = '0;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // ------------------------------------------------------------------
   // Per-byte decode of the byte at index idx_ff.
   // ------------------------------------------------------------------
   logic [31:0]          byte_addr;
   logic [31:0]          lfb_off;
   logic                 lfb_hit;
   logic [31:0]          masked;
   logic                 above_ram;
   logic                 in_win;
   logic [31:0]          win_rel;
   logic [31:0]          bank_off;
   logic [7:0]           wbyte;
   src_type              dec_src;
   logic [VRAM_AW-1:0]   dec_vaddr;

   assign byte_addr = addr_ff + {30'd0, idx_ff};
   assign lfb_off   = byte_addr - lfb_base_ff;
   assign lfb_hit   = (lfb_base_ff != '0) && (byte_addr >= lfb_base_ff) && (lfb_off < vsize);
   assign masked    = a20_enable_ff ? byte_addr : (byte_addr & ~A20_BIT);
   assign above_ram = masked >= RAM_BYTES;
   assign in_win    = (masked >= WIN_LO) && (masked < WIN_HI);
   assign win_rel   = masked - WIN_LO;
   assign bank_off  = {12'd0, window_offset_ff} + win_rel;
   assign wbyte     = wdata_ff[{idx_ff, 3'b000} +: 8];

   always_comb begin
      dec_vaddr = lfb_off[VRAM_AW-1:0];
      if (lfb_hit) begin
         dec_src = SRC_VIDEO;
      end else if (above_ram) begin
         dec_src = SRC_OPEN;
      end else if (bank_window_enable_ff && in_win) begin
         dec_vaddr = bank_off[VRAM_AW-1:0];
         dec_src   = (bank_off >= vsize) ? SRC_OPEN : SRC_VIDEO;
      end else if (planar_mode_ff && in_win) begin
         dec_src = SRC_PLANE;
      end else begin
         dec_src = SRC_MAIN;
      end
   end

   // ------------------------------------------------------------------
   // Memory ports: the clearing pass or the issued byte.
   // ------------------------------------------------------------------
   logic                    main_we;
   logic [RAM_AW-1:0]       main_addr;
   logic [7:0]              main_wd;
   logic                    video_we;
   logic [VRAM_AW-1:0]      video_addr;
   logic [7:0]              video_wd;
   logic [PLANE_COUNT-1:0]  plane_we;
   logic [PLANE_AW-1:0]     plane_addr;
   logic [7:0]              plane_wd;
   logic                    wr_issue;

   assign wr_issue = issue && kind_ff;

   always_comb begin
      if (clearing) begin
         main_we    = 32'(clr_cnt_ff) < RAM_BYTES;
         main_addr  = clr_cnt_ff[RAM_AW-1:0];
         main_wd    = '0;
         video_we   = 32'(clr_cnt_ff) < VRAM_BYTES;
         video_addr = clr_cnt_ff[VRAM_AW-1:0];
         video_wd   = '0;
         plane_we   = {PLANE_COUNT{32'(clr_cnt_ff) < PLANE_BYTES}};
         plane_addr = clr_cnt_ff[PLANE_AW-1:0];
         plane_wd   = '0;
      end else begin
         main_we    = wr_issue && (dec_src == SRC_MAIN);
         main_addr  = masked[RAM_AW-1:0];
         main_wd    = wbyte;
         video_we   = wr_issue && (dec_src == SRC_VIDEO);
         video_addr = dec_vaddr;
         video_wd   = wbyte;
         plane_we   = (wr_issue && (dec_src == SRC_PLANE)) ? write_plane_mask_ff : '0;
         plane_addr = win_rel[PLANE_AW-1:0];
         plane_wd   = wbyte;
      end
   end

   logic [7:0] main_mem  [RAM_BYTES];
   logic [7:0] video_mem [VRAM_BYTES];
   logic [7:0] plane_mem [PLANE_COUNT][PLANE_BYTES];
   logic [7:0] main_rd_ff;
   logic [7:0] video_rd_ff;
   logic [7:0] plane_rd_ff [PLANE_COUNT];

   always_ff @(posedge clock) begin
      if (main_we) begin
         main_mem[main_addr] <= main_wd;
      end
      if (issue) begin
         main_rd_ff <= main_mem[main_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (video_we) begin
         video_mem[video_addr] <= video_wd;
      end
      if (issue) begin
         video_rd_ff <= video_mem[video_addr];
      end
   end

   // Each plane is a bank of its own, so a planar write reaches all masked planes at once.
   always_ff @(posedge clock) begin
      for (int p = 0; p < PLANE_COUNT; p++) begin
         if (plane_we[p]) begin
            plane_mem[p][plane_addr] <= plane_wd;
         end
         if (issue) begin
            plane_rd_ff[p] <= plane_mem[p][plane_addr];
         end
      end
   end

   // ------------------------------------------------------------------
   // Result assembly.
   // ------------------------------------------------------------------
   logic [7:0]  pend_byte;
   logic [31:0] merged;

   always_comb begin
      case (pend_src_ff)
         SRC_OPEN:  pend_byte = OPEN_BUS;
         SRC_MAIN:  pend_byte = main_rd_ff;
         SRC_VIDEO: pend_byte = video_rd_ff;
         SRC_PLANE: pend_byte = plane_rd_ff[read_plane_ff];
         default:   pend_byte = '0;
      endcase
   end

   assign merged = pend_valid_ff ? (result_ff | ({24'd0, pend_byte} << {pend_lane_ff, 3'b000}))
                                 : result_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_cnt_ff    <= '0;
         idx_ff        <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_cnt_ff    <= clr_cnt_in;
         idx_ff        <= idx_in;
         pend_valid_ff <= issue;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      result_ff <= req_accept ? '0 : merged;
      if (issue) begin
         pend_src_ff  <= kind_ff ? SRC_NONE : dec_src;
         pend_lane_ff <= idx_ff;
      end
      if (req_accept) begin
         kind_ff  <= req_kind;
         addr_ff  <= req_address;
         wdata_ff <= req_write_data;
         case (req_width_code)
            WC_BYTE: last_idx_ff <= 2'd0;
            WC_HALF: last_idx_ff <= 2'd1;
            default: last_idx_ff <= 2'd3;
         endcase
      end
      if (load_out) begin
         rsp_data_ff <= merged;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_data_ff;

   // ------------------------------------------------------------------
   // Assertions.
   // ------------------------------------------------------------------
   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("result beat raised outside the finishing cycle");

   a_no_req_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> req_stall)
      else $error("request beat possible during the clearing pass");

   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> (idx_ff <= last_idx_ff))
      else $error("byte index ran past the access width");

   a_pend_after_run: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> $past(state_ff == ST_RUN))
      else $error("pending byte without an issue cycle");

   a_read_no_write: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_RUN) && !kind_ff) |-> !(main_we || video_we || (plane_we != '0)))
      else $error("memory written during a read access");

endmodule

`default_nettype wire

FILE: verif/tb_pc_memory_map_decoder.sv
// Self-checking testbench for the PC memory map decoder: directed and random accesses.
module tb_pc_memory_map_decoder import pcmmd_pkg::*; ;

   timeunit 1ns;
   timeprecision 1ps;

   // Access kinds and the width codes that the package does not name.
   localparam logic       KIND_READ  = 1'b0;
   localparam logic       KIND_WRITE = 1'b1;
   localparam logic [1:0] WC_WORD    = 2'd2;
   // The spare width code behaves as a four-byte access.
   localparam logic [1:0] WC_SPARE   = 2'd3;

   localparam int PHASE_ITEMS = 150;

   typedef struct packed {
      logic        kind;
      logic [1:0]  width_code;
      logic [31:0] address;
      logic [31:0] write_data;
   } access_type;

   // One access together with the read data it must return.
   typedef struct packed {
      access_type  access;
      logic [31:0] read_data;
   } read_expect_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_kind = KIND_READ;
   logic [1:0]  req_width_code = WC_BYTE;
   logic [31:0] req_address = '0;
   logic [31:0] req_write_data = '0;

   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_read_data;

   logic        csr_write_enable = 1'b0;
   logic [2:0]  csr_index = CSR_A20_ENABLE;
   logic [31:0] csr_write_data = '0;

   pc_memory_map_decoder DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_kind         (req_kind),
      .req_width_code   (req_width_code),
      .req_address      (req_address),
      .req_write_data   (req_write_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_read_data    (rsp_read_data),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Shadow copy of the decoder: its registers and its three stores.
   // The stores are two-state, so they start out as zero, just as the
   // clearing pass leaves the real ones.
   // ------------------------------------------------------------------
   logic        cfg_a20;
   logic [31:0] cfg_lfb_base;
   logic [20:0] cfg_vram_bytes;
   logic        cfg_bank_en;
   logic [19:0] cfg_win_offset;
   logic        cfg_planar;
   logic [1:0]  cfg_read_plane;
   logic [3:0]  cfg_plane_mask;

   bit [7:0] main_mem  [0:RAM_BYTES-1];
   bit [7:0] video_mem [0:VRAM_BYTES-1];
   bit [7:0] plane_mem [0:PLANE_COUNT*PLANE_BYTES-1];

   access_type      pending_accesses [$];
   read_expect_type expected_reads [$];
   logic [31:0]     recent_addresses [$];

   int accesses_queued = 0;
   int results_seen    = 0;
   int mismatch_count  = 0;

   // Sender burst shaping and receiver stall pattern.
   int burst_left = 0;
   int gap_left   = 0;
   int stall_left = 0;
   bit stall_level = 1'b0;

   // Video memory in use: the register value, but never more than is fitted.
   function automatic logic [31:0] video_size();
      return (cfg_vram_bytes < VRAM_BYTES) ? 32'(cfg_vram_bytes) : 32'(VRAM_BYTES);
   endfunction

   // Decodes one byte of an access, updates the shadow stores on a write and
   // returns the byte read (zero for a write).
   function automatic logic [7:0] touch_byte(logic [31:0] a, logic wr, logic [7:0] val);
      logic [31:0] vs;
      logic [31:0] m;
      logic [31:0] off;
      logic [31:0] po;
      vs = video_size();

      // The framebuffer aperture sees the address before the A20 gate.
      if (cfg_lfb_base != 0 && a >= cfg_lfb_base && (a - cfg_lfb_base) < vs) begin
         off = a - cfg_lfb_base;
         if (wr) begin
            video_mem[off] = val;
            return 8'h00;
         end
         return video_mem[off];
      end

      m = cfg_a20 ? a : (a & ~A20_BIT);
      if (m >= RAM_BYTES)
         return wr ? 8'h00 : OPEN_BUS;

      // The bank window takes precedence over planar mode.
      if (cfg_bank_en && m >= WIN_LO && m < WIN_HI) begin
         off = 32'(cfg_win_offset) + (m - WIN_LO);
         if (off >= vs)
            return wr ? 8'h00 : OPEN_BUS;
         if (wr) begin
            video_mem[off] = val;
            return 8'h00;
         end
         return video_mem[off];
      end

      if (cfg_planar && m >= WIN_LO && m < WIN_HI) begin
         po = (m - WIN_LO) & (PLANE_BYTES - 1);
         if (!wr)
            return plane_mem[32'(cfg_read_plane) * PLANE_BYTES + po];
         for (int p = 0; p < PLANE_COUNT; p++)
            if (cfg_plane_mask[p])
               plane_mem[p * PLANE_BYTES + po] = val;
         return 8'h00;
      end

      if (wr) begin
         main_mem[m] = val;
         return 8'h00;
      end
      return main_mem[m];
   endfunction

   // Works out the read data of a whole access, byte by byte, low byte first.
   // Each byte address wraps at 32 bits on its own.
   function automatic logic [31:0] predict_access(access_type acc);
      int          nbytes;
      logic [31:0] result;
      logic [7:0]  b;
      nbytes = (acc.width_code == WC_BYTE) ? 1 : (acc.width_code == WC_HALF) ? 2 : 4;
      result = '0;
      for (int i = 0; i < nbytes; i++) begin
         b = touch_byte(acc.address + 32'(i), acc.kind, acc.write_data[8*i +: 8]);
         if (acc.kind == KIND_READ)
            result[8*i +: 8] = b;
      end
      return result;
   endfunction

   // The shadow registers follow the configuration port as the block sees it.
   always @(posedge clock) begin
      if (reset) begin
         cfg_a20        <= 1'b0;
         cfg_lfb_base   <= '0;
         cfg_vram_bytes <= '0;
         cfg_bank_en    <= 1'b0;
         cfg_win_offset <= '0;
         cfg_planar     <= 1'b0;
         cfg_read_plane <= '0;
         cfg_plane_mask <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_A20_ENABLE:         cfg_a20        <= csr_write_data[0];
            CSR_LFB_BASE:           cfg_lfb_base   <= csr_write_data;
            CSR_VRAM_BYTES:         cfg_vram_bytes <= csr_write_data[20:0];
            CSR_BANK_WINDOW_ENABLE: cfg_bank_en    <= csr_write_data[0];
            CSR_WINDOW_OFFSET:      cfg_win_offset <= csr_write_data[19:0];
            CSR_PLANAR_MODE:        cfg_planar     <= csr_write_data[0];
            CSR_READ_PLANE:         cfg_read_plane <= csr_write_data[1:0];
            CSR_WRITE_PLANE_MASK:   cfg_plane_mask <= csr_write_data[3:0];
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Request driver. A beat is taken at an edge where valid is high and
   // stall is low; that is the moment the shadow model executes it. The
   // next beat is only loaded once the current one has gone, so a stalled
   // payload never moves. Beats go out in bursts of random length with
   // random gaps, some of them zero, between the bursts.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      access_type      nxt;
      read_expect_type taken;
      if (reset) begin
         req_valid  <= 1'b0;
         burst_left = 0;
         gap_left   = 0;
      end else begin
         if (req_valid && !req_stall) begin
            taken.access.kind       = req_kind;
            taken.access.width_code = req_width_code;
            taken.access.address    = req_address;
            taken.access.write_data = req_write_data;
            taken.read_data         = predict_access(taken.access);
            expected_reads.push_back(taken);
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_accesses.size() > 0) begin
               nxt = pending_accesses.pop_front();
               req_kind       <= nxt.kind;
               req_width_code <= nxt.width_code;
               req_address    <= nxt.address;
               req_write_data <= nxt.write_data;
               req_valid      <= 1'b1;
               if (burst_left <= 1) begin
                  burst_left = $urandom_range(1, 16);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
               end else begin
                  burst_left--;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Result monitor. Every result beat is matched against the oldest
   // expectation; the stall pattern mixes short stalled stretches, one
   // draw in four, with longer free-running ones.
   // ------------------------------------------------------------------
   task automatic report_mismatch(string what);
      mismatch_count++;
      $display("[%0t] mismatch: %s", $time, what);
   endtask

   always @(posedge clock) begin
      read_expect_type want;
      if (reset) begin
         rsp_stall   <= 1'b0;
         stall_left  = 0;
         stall_level = 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (expected_reads.size() == 0) begin
               report_mismatch($sformatf("result beat with nothing outstanding, read_data %h",
                                         rsp_read_data));
            end else begin
               want = expected_reads.pop_front();
               if (rsp_read_data !== want.read_data)
                  report_mismatch($sformatf("%s code %0d at %h data %h: read_data %h, expected %h",
                                            want.access.kind ? "write" : "read",
                                            want.access.width_code, want.access.address,
                                            want.access.write_data, rsp_read_data,
                                            want.read_data));
            end
         end
         if (stall_left == 0) begin
            stall_level = ($urandom_range(0, 3) == 0);
            stall_left  = stall_level ? $urandom_range(1, 8) : $urandom_range(1, 40);
         end
         stall_left--;
         rsp_stall <= stall_level;
      end
   end

   // ------------------------------------------------------------------
   // Stimulus helpers.
   // ------------------------------------------------------------------
   task automatic queue_access(logic kind, logic [1:0] wc, logic [31:0] addr, logic [31:0] data);
      access_type acc;
      acc.kind       = kind;
      acc.width_code = wc;
      acc.address    = addr;
      acc.write_data = data;
      pending_accesses.push_back(acc);
      accesses_queued++;
   endtask

   // One register write; the enable drops between writes.
   task automatic write_csr(logic [2:0] idx, logic [31:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic apply_setting(logic a20, logic [31:0] lfb, logic [31:0] vram, logic bank,
                                logic [31:0] woff, logic planar, logic [1:0] rplane,
                                logic [3:0] mask);
      write_csr(CSR_A20_ENABLE, 32'(a20));
      write_csr(CSR_LFB_BASE, lfb);
      write_csr(CSR_VRAM_BYTES, vram);
      write_csr(CSR_BANK_WINDOW_ENABLE, 32'(bank));
      write_csr(CSR_WINDOW_OFFSET, woff);
      write_csr(CSR_PLANAR_MODE, 32'(planar));
      write_csr(CSR_READ_PLANE, 32'(rplane));
      write_csr(CSR_WRITE_PLANE_MASK, 32'(mask));
   endtask

   // Picks a setting with a bias towards the edges: aperture at zero, at the
   // very top, overlapping RAM or wrapping; video memory absent, full or tiny;
   // the bank window starting so that its end of video memory falls inside it.
   task automatic random_setting();
      logic [31:0] lfb;
      logic [31:0] vram;
      logic [31:0] woff;
      case ($urandom_range(0, 5))
         0: lfb = 32'h0000_0000;
         1: lfb = 32'hFFFF_FFFF;
         2: lfb = $urandom;
         3: lfb = 32'h0008_0000;
         4: lfb = 32'hFFFF_F000;
         default: lfb = 32'hE000_0000;
      endcase
      case ($urandom_range(0, 3))
         0: vram = 0;
         1: vram = VRAM_BYTES;
         2: vram = $urandom_range(0, VRAM_BYTES);
         default: vram = $urandom_range(1, 4096);
      endcase
      case ($urandom_range(0, 3))
         0: woff = 0;
         1: woff = 32'h000F_FFFF;
         2: woff = $urandom_range(0, 32'h000F_FFFF);
         default: woff = (vram > 64) ? vram - 64 : 0;
      endcase
      apply_setting(1'($urandom_range(0, 1)), lfb, vram, 1'($urandom_range(0, 1)), woff,
                    1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                    4'($urandom_range(0, 15)));
   endtask

   // Addresses cluster on the interesting edges of the map so that writes
   // and later reads meet; one pick in eleven is fully random.
   function automatic logic [31:0] pick_address();
      logic [31:0] vs;
      vs = video_size();
      case ($urandom_range(0, 10))
         0: return $urandom_range(0, 255);
         1: return 32'h0009_FFF0 + $urandom_range(0, 31);
         2: return WIN_LO + $urandom_range(0, 127);
         3: return WIN_HI - 16 + $urandom_range(0, 31);
         4: return A20_BIT + $urandom_range(0, 255);
         5: return A20_BIT + WIN_LO + $urandom_range(0, 127);
         6: return RAM_BYTES - 16 + $urandom_range(0, 31);
         7: return ($urandom_range(0, 1) == 0) ? cfg_lfb_base - 4 + $urandom_range(0, 127)
                                              : cfg_lfb_base + vs - 8 + $urandom_range(0, 15);
         8: return 32'hFFFF_FFF0 + $urandom_range(0, 15);
         9: return WIN_LO + ((vs - 32'(cfg_win_offset)) & 32'h0000_FFFF) - 8
                   + $urandom_range(0, 15);
         default: return $urandom;
      endcase
   endfunction

   // Mostly fresh addresses, but a quarter of the accesses revisit a recent one
   // so that reads see what earlier writes left behind.
   task automatic queue_random_access();
      logic [31:0] addr;
      if (recent_addresses.size() > 0 && $urandom_range(0, 3) == 0) begin
         addr = recent_addresses[$urandom_range(0, recent_addresses.size() - 1)];
      end else begin
         addr = pick_address();
         recent_addresses.push_back(addr);
         if (recent_addresses.size() > 16)
            void'(recent_addresses.pop_front());
      end
      queue_access(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)), addr, $urandom);
   endtask

   // Waits until every queued access has answered, then for the pipeline to
   // settle; sampled on the falling edge, away from the driving edge.
   task automatic wait_drained();
      while (results_seen != accesses_queued)
         @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   // ------------------------------------------------------------------
   // Test sequence.
   // ------------------------------------------------------------------
   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Plain RAM, the A20 alias and the wrap at the top of the address
      // space, with a bank window that has no video memory behind it (so it
      // reads open bus) and planar mode shadowed by it. These writes land
      // while the clearing pass is still running.
      apply_setting(1'b0, 32'h0, 32'h0, 1'b1, 32'h000F_FFFF, 1'b1, 2'd0, 4'h0);
      queue_access(KIND_WRITE, WC_WORD,  32'h0000_0000, 32'hDEAD_BEEF);
      queue_access(KIND_READ,  WC_WORD,  32'h0000_0000, 32'h0);
      queue_access(KIND_READ,  WC_BYTE,  32'h0010_0001, 32'h0);
      queue_access(KIND_WRITE, WC_HALF,  32'h001F_FFFF, 32'h0000_1234);
      queue_access(KIND_READ,  WC_SPARE, 32'h000F_FFFE, 32'h0);
      queue_access(KIND_WRITE, WC_BYTE,  32'h000A_0000, 32'h0000_0055);
      queue_access(KIND_READ,  WC_WORD,  32'h0009_FFFE, 32'h0);
      queue_access(KIND_READ,  WC_WORD,  32'hFFFF_FFFE, 32'h0);
      queue_access(KIND_WRITE, WC_WORD,  32'h0000_0010, 32'hFFFF_FFFF);
      queue_access(KIND_READ,  WC_WORD,  32'h0000_0010, 32'h0);
      wait_drained();

      // Full video memory behind a high aperture and the bank window at
      // offset zero; with A20 open, addresses above 1 MiB float.
      apply_setting(1'b1, 32'hE000_0000, VRAM_BYTES, 1'b1, 32'h0, 1'b0, 2'd3, 4'hF);
      queue_access(KIND_WRITE, WC_WORD,  32'hE000_0000, 32'hA5A5_5A5A);
      queue_access(KIND_READ,  WC_WORD,  32'h000A_0000, 32'h0);
      queue_access(KIND_READ,  WC_WORD,  32'hE00F_FFFE, 32'h0);
      queue_access(KIND_READ,  WC_BYTE,  32'h0010_0000, 32'h0);
      queue_access(KIND_WRITE, WC_WORD,  32'h000A_FFFE, 32'h0102_0304);
      queue_access(KIND_READ,  WC_WORD,  32'hE000_FFFE, 32'h0);
      wait_drained();

      // A tiny aperture in the last bytes of the address space, and planar
      // mode writing two planes at once, also through the A20 alias.
      apply_setting(1'b0, 32'hFFFF_FFF8, 32'h10, 1'b0, 32'h0, 1'b1, 2'd2, 4'h5);
      queue_access(KIND_WRITE, WC_WORD,  32'hFFFF_FFFE, 32'hCAFE_F00D);
      queue_access(KIND_READ,  WC_WORD,  32'hFFFF_FFFC, 32'h0);
      queue_access(KIND_WRITE, WC_WORD,  32'h000A_0100, 32'h1122_3344);
      queue_access(KIND_READ,  WC_WORD,  32'h000A_0100, 32'h0);
      queue_access(KIND_WRITE, WC_BYTE,  32'h001A_0100, 32'h0000_0077);
      queue_access(KIND_READ,  WC_HALF,  32'h000A_FFFF, 32'h0);
      wait_drained();

      // The other pair of planes.
      apply_setting(1'b0, 32'hFFFF_FFF8, 32'h10, 1'b0, 32'h0, 1'b1, 2'd1, 4'hA);
      queue_access(KIND_READ,  WC_WORD,  32'h000A_0100, 32'h0);
      queue_access(KIND_WRITE, WC_WORD,  32'h000A_0100, 32'h9988_7766);
      queue_access(KIND_READ,  WC_WORD,  32'h000A_0100, 32'h0);
      wait_drained();

      // Random phases: the first with every register at its top value (video memory at VRAM_BYTES),
      // the last with every register at zero, the rest drawn at random.
      for (int phase = 0; phase < 8; phase++) begin
         if (phase == 0)
            apply_setting(1'b1, 32'hFFFF_FFFF, VRAM_BYTES, 1'b1, 32'h000F_FFFF, 1'b1, 2'd3, 4'hF);
         else if (phase == 7)
            apply_setting(1'b0, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0, 2'd0, 4'h0);
         else
            random_setting();
         for (int n = 0; n < PHASE_ITEMS; n++)
            queue_random_access();
         wait_drained();
      end

      if (expected_reads.size() != 0)
         report_mismatch($sformatf("%0d expected results never arrived", expected_reads.size()));

      if (mismatch_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

   // This limit leaves ample margin over the clearing pass.
   initial begin
      #40_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule
